// ----- rtl/core/tcsq_pkg.sv -----
// Shared types, codes and defaults for the two-class transmit slot queue.
// Used by tcsq_scan and two_class_tx_slot_queue_unit; depends on nothing.
`default_nettype none

package tcsq_pkg;

    // Default geometry of the slot ring.
    localparam int QUEUE_SLOTS_DEF = 4;
    localparam int SLOT_BYTES_DEF  = 256;

    // Fixed field widths of the item formats.
    localparam int CMD_W    = 2;
    localparam int LEN_W    = 10;
    localparam int IDX_W    = 2;
    localparam int COUNT_W  = 3;
    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 24;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ENQUEUE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TRANSPORT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd2;

    // Packet class codes.
    localparam logic CLASS_CTRL = 1'b0;
    localparam logic CLASS_TELE = 1'b1;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_RESULT
    } t_state;

    // Status handed back by the telemetry scan unit.
    typedef struct packed {
        logic done;
        logic found;
    } t_scan_status;

endpackage

`default_nettype wire

// ----- rtl/core/tcsq_scan.sv -----
// Iterative search for the oldest replaceable telemetry slot in the ring.
// Examines one slot per cycle; depends on tcsq_pkg.
`default_nettype none

module tcsq_scan #(
    parameter  int QUEUE_SLOTS = tcsq_pkg::QUEUE_SLOTS_DEF,
    localparam int IW          = (QUEUE_SLOTS > 2) ? $clog2(QUEUE_SLOTS) : 1,
    localparam int CW          = $clog2(QUEUE_SLOTS + 1)
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic [IW-1:0]                        i_head,
    input  wire logic [CW-1:0]                        i_count,
    input  wire logic                                 i_head_sent,
    input  wire logic                                 i_tele_bit,
    output logic      [IW-1:0]                        o_rd_addr,
    output logic      [IW-1:0]                        o_index,
    output tcsq_pkg::t_scan_status                    o_status
);

    logic          r_busy;
    logic          r_done;
    logic          r_found;
    logic [CW-1:0] r_k;
    logic [IW-1:0] r_ptr;
    logic [IW-1:0] r_idx;
    logic          hit;

    // A slot qualifies when it is telemetry and is not a part-sent head.
    assign hit = i_tele_bit && !((r_k == '0) && i_head_sent);

    // Walk the occupied part of the ring, one slot each cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_found <= 1'b0;
                r_k     <= '0;
                r_ptr   <= i_head;
            end else if (r_busy) begin
                if (r_k >= i_count) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else if (hit) begin
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                    r_found <= 1'b1;
                    r_idx   <= r_ptr;
                end else begin
                    r_k   <= r_k + 1'b1;
                    r_ptr <= (r_ptr == IW'(QUEUE_SLOTS - 1)) ? '0 : r_ptr + 1'b1;
                end
            end
        end
    end

    assign o_rd_addr       = r_ptr;
    assign o_index         = r_idx;
    assign o_status.done   = r_done;
    assign o_status.found  = r_found;

    // The examined position never runs past the occupied slots.
    a_k_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_k <= i_count))
        else $error("scan position beyond occupied slots");

    // A finished scan leaves the unit idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("scan reports done while still busy");

    // A start always leads to a busy cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("scan did not start");

endmodule

`default_nettype wire

// ----- rtl/core/two_class_tx_slot_queue_unit.sv -----
// Top level of the two-class transmit slot queue: ring metadata, sequencer
// and result register. Depends on tcsq_pkg and tcsq_scan.
//
// Usage:
// Commands arrive on the s_axis channel and each one yields exactly one
// result item on the m_axis channel. s_axis_tuser carries the command and
// the packet class, s_axis_tdata the packet length and accepted byte count.
// The result reports the outcome and the ring state after the command.
// A taken command passes through the EXEC state, where the result item is
// registered, and is then presented in the RESULT state; a telemetry enqueue
// first passes through the SCAN state, in which the scan unit examines one
// ring slot per cycle to find the oldest telemetry packet that may be
// replaced.
// s_axis_tready is high only while the block is idle, so one item is in
// work at a time. While m_axis_tready is low the result is held and no new
// item is taken. Reset empties the ring, zeroes the head offset and drops
// any pending result; slot contents are only read once written.
`default_nettype none

module two_class_tx_slot_queue_unit #(
    parameter int QUEUE_SLOTS = tcsq_pkg::QUEUE_SLOTS_DEF,
    parameter int SLOT_BYTES  = tcsq_pkg::SLOT_BYTES_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [9:0] packet_length, [19:10] accepted_bytes, [23:20] zero
    input  wire logic [tcsq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [1:0] command, [2] item_class
    input  wire logic [tcsq_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [0] ok, [2:1] slot_index, [3] coalesced, [4] frame_done,
    // [6:5] head_slot, [16:7] head_offset, [19:17] queue_count,
    // [20] ctrl_pending, [23:21] zero
    output logic      [tcsq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int IW = (QUEUE_SLOTS > 2) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int CW = $clog2(QUEUE_SLOTS + 1);
    localparam int LW = tcsq_pkg::LEN_W;

    tcsq_pkg::t_state r_state, n_state;

    // Captured command item.
    logic [tcsq_pkg::CMD_W-1:0] r_cmd;
    logic                       r_tele;
    logic [LW-1:0]              r_plen;
    logic [LW-1:0]              r_acc;

    // Ring metadata.
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ctrl, n_ctrl;
    logic [LW-1:0] r_offset, n_offset;
    logic [LW-1:0] r_len     [QUEUE_SLOTS];
    logic          r_is_tele [QUEUE_SLOTS];

    // Slot write and read port.
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic          wr_tele;
    logic [IW-1:0] rd_addr;
    logic          rd_tele;

    // Scan unit hookup.
    logic                   scan_start;
    logic [IW-1:0]          scan_addr;
    logic [IW-1:0]          scan_idx;
    tcsq_pkg::t_scan_status scan_stat;

    // Result fields and the registered result item.
    logic                                 res_ok, res_coal, res_done;
    logic [IW-1:0]                        res_sidx;
    logic [tcsq_pkg::OUT_TDATA_W-1:0]     n_res;
    logic [tcsq_pkg::OUT_TDATA_W-1:0]     r_res;

    // Transport arithmetic on the head slot.
    logic [LW-1:0] head_len;
    logic [LW-1:0] rem;
    logic [LW-1:0] take;
    logic [LW-1:0] sent;
    logic          len_ok;
    logic          accept;
    logic          pop;
    logic [IW-1:0] head_inc;
    logic [IW-1:0] tail_inc;

    assign accept = s_axis_tvalid && s_axis_tready;

    // Start a scan for every telemetry enqueue as it is taken.
    assign scan_start = accept
                        && (s_axis_tuser[1:0] == tcsq_pkg::CMD_ENQUEUE)
                        && (s_axis_tuser[2] == tcsq_pkg::CLASS_TELE);

    tcsq_scan #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (scan_start),
        .i_head      (r_head),
        .i_count     (r_count),
        .i_head_sent (r_offset != '0),
        .i_tele_bit  (rd_tele),
        .o_rd_addr   (scan_addr),
        .o_index     (scan_idx),
        .o_status    (scan_stat)
    );

    // One class read port, shared between the scan and the head.
    assign rd_addr  = (r_state == tcsq_pkg::ST_SCAN) ? scan_addr : r_head;
    assign rd_tele  = r_is_tele[rd_addr];
    assign head_len = r_len[r_head];

    assign head_inc = (r_head == IW'(QUEUE_SLOTS - 1)) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == IW'(QUEUE_SLOTS - 1)) ? '0 : r_tail + 1'b1;
    assign len_ok   = (r_plen != '0) && (r_plen <= LW'(SLOT_BYTES));

    // Remaining bytes of the head and the clamped byte count.
    assign rem  = (head_len > r_offset) ? head_len - r_offset : '0;
    assign take = (r_acc < rem) ? r_acc : rem;
    assign sent = r_offset + take;

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcsq_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = scan_start ? tcsq_pkg::ST_SCAN : tcsq_pkg::ST_EXEC;
                end
            end
            tcsq_pkg::ST_SCAN: begin
                if (scan_stat.done) begin
                    n_state = tcsq_pkg::ST_EXEC;
                end
            end
            tcsq_pkg::ST_EXEC: begin
                n_state = tcsq_pkg::ST_RESULT;
            end
            tcsq_pkg::ST_RESULT: begin
                if (m_axis_tready) begin
                    n_state = tcsq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcsq_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake outputs follow the state.
    always_comb begin
        s_axis_tready = (r_state == tcsq_pkg::ST_IDLE);
        m_axis_tvalid = (r_state == tcsq_pkg::ST_RESULT);
    end

    // Command execution: next ring state, slot write and result fields.
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_ctrl   = r_ctrl;
        n_offset = r_offset;
        wr_en    = 1'b0;
        wr_idx   = r_tail;
        wr_tele  = r_tele;
        res_ok   = 1'b0;
        res_coal = 1'b0;
        res_done = 1'b0;
        res_sidx = '0;
        pop      = 1'b0;
        unique case (r_cmd)
            tcsq_pkg::CMD_ENQUEUE: begin
                if (len_ok) begin
                    if (r_tele && scan_stat.found) begin
                        // Coalesce into the oldest replaceable telemetry slot.
                        wr_en    = 1'b1;
                        wr_idx   = scan_idx;
                        wr_tele  = tcsq_pkg::CLASS_TELE;
                        res_ok   = 1'b1;
                        res_coal = 1'b1;
                        res_sidx = scan_idx;
                    end else if (r_tele
                                 ? ((r_ctrl == '0)
                                    && ((CW+1)'(r_count) + (CW+1)'(2)
                                        <= (CW+1)'(QUEUE_SLOTS)))
                                 : (r_count != CW'(QUEUE_SLOTS))) begin
                        // Append at the tail.
                        wr_en    = 1'b1;
                        n_tail   = tail_inc;
                        n_count  = r_count + 1'b1;
                        res_ok   = 1'b1;
                        res_sidx = r_tail;
                        if (!r_tele) begin
                            n_ctrl = r_ctrl + 1'b1;
                        end
                    end
                end
            end
            tcsq_pkg::CMD_TRANSPORT: begin
                if (r_count != '0) begin
                    res_ok = 1'b1;
                    if (head_len == '0) begin
                        pop = 1'b1;
                    end else if ((take != '0) || (rem == '0)) begin
                        n_offset = sent;
                        pop      = (sent >= head_len);
                    end
                end
                if (pop) begin
                    res_done = 1'b1;
                    n_head   = head_inc;
                    n_count  = r_count - 1'b1;
                    n_offset = '0;
                    if (rd_tele == tcsq_pkg::CLASS_CTRL) begin
                        n_ctrl = r_ctrl - 1'b1;
                    end
                end
            end
            tcsq_pkg::CMD_CLEAR: begin
                n_head   = '0;
                n_tail   = '0;
                n_count  = '0;
                n_ctrl   = '0;
                n_offset = '0;
                res_ok   = 1'b1;
            end
            default: begin
                res_ok = 1'b0;
            end
        endcase
    end

    // Pack the result item from the state after the command.
    always_comb begin
        n_res        = '0;
        n_res[0]     = res_ok;
        n_res[2:1]   = tcsq_pkg::IDX_W'(res_sidx);
        n_res[3]     = res_coal;
        n_res[4]     = res_done;
        n_res[6:5]   = tcsq_pkg::IDX_W'(n_head);
        n_res[16:7]  = n_offset;
        n_res[19:17] = tcsq_pkg::COUNT_W'(n_count);
        n_res[20]    = (n_ctrl != '0);
    end

    assign m_axis_tdata = r_res;

    // Control registers and ring pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tcsq_pkg::ST_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_ctrl   <= '0;
            r_offset <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == tcsq_pkg::ST_EXEC) begin
                r_head   <= n_head;
                r_tail   <= n_tail;
                r_count  <= n_count;
                r_ctrl   <= n_ctrl;
                r_offset <= n_offset;
            end
        end
    end

    // Captured item, slot contents and the result register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= s_axis_tuser[1:0];
            r_tele <= s_axis_tuser[2];
            r_plen <= s_axis_tdata[9:0];
            r_acc  <= s_axis_tdata[19:10];
        end
        if ((r_state == tcsq_pkg::ST_EXEC) && wr_en) begin
            r_len[wr_idx]     <= r_plen;
            r_is_tele[wr_idx] <= wr_tele;
        end
        if (r_state == tcsq_pkg::ST_EXEC) begin
            r_res <= n_res;
        end
    end

    // The ring never holds more than its slots, nor more control than queued packets.
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CW'(QUEUE_SLOTS)) && (r_ctrl <= r_count))
        else $error("slot or control count out of range");

    // A part-sent head implies a non-empty ring.
    a_offset_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_offset != '0) |-> (r_count != '0))
        else $error("send offset without a queued packet");

    // Only one item is in work: no intake while a result waits.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is pending");

    // A coalesced result always reports an accepted enqueue.
    a_coal_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[3]) |-> m_axis_tdata[0])
        else $error("coalesced without ok");

endmodule

`default_nettype wire

// ----- tb/sv/two_class_tx_slot_queue_unit_tb.sv -----
// Self-checking testbench for the two-class transmit slot queue unit.
// Drives commands on the input stream and checks every result item against a
// behavioural copy of the slot ring; depends on tcsq_pkg and the RTL only.
`default_nettype none

module two_class_tx_slot_queue_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOTS       = tcsq_pkg::QUEUE_SLOTS_DEF;
    localparam int MAX_BYTES    = tcsq_pkg::SLOT_BYTES_DEF;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = NSLOTS + 12;
    localparam int RANDOM_ITEMS = 1014;

    // Command code the block does not know; it must answer with ok low.
    localparam logic [tcsq_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    // One result item, as unpacked from the output stream.
    typedef struct {
        logic                         ok;
        logic [tcsq_pkg::IDX_W-1:0]   slot_index;
        logic                         coalesced;
        logic                         frame_done;
        logic [tcsq_pkg::IDX_W-1:0]   head_slot;
        logic [tcsq_pkg::LEN_W-1:0]   head_offset;
        logic [tcsq_pkg::COUNT_W-1:0] queue_count;
        logic                         ctrl_pending;
    } t_queue_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    // [9:0] packet_length, [19:10] accepted_bytes, [23:20] zero
    logic [tcsq_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // [1:0] command, [2] item_class
    logic [tcsq_pkg::IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    // [0] ok, [2:1] slot_index, [3] coalesced, [4] frame_done, [6:5] head_slot,
    // [16:7] head_offset, [19:17] queue_count, [20] ctrl_pending, [23:21] zero
    logic [tcsq_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // Behavioural copy of the ring metadata.
    int   ring_head;
    int   ring_tail;
    int   ring_count;
    int   head_sent;
    int   slot_len  [NSLOTS];
    logic slot_tele [NSLOTS];

    t_queue_result expected_results[$];
    int   error_count    = 0;
    logic tx_idle_on     = 1'b1;
    logic rx_idle_on     = 1'b1;
    int   rx_holds_asked = 0;

    two_class_tx_slot_queue_unit #(
        .QUEUE_SLOTS (NSLOTS),
        .SLOT_BYTES  (MAX_BYTES)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Free-running clock, 4 ns period.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Ring model
    // ------------------------------------------------------------------

    function automatic void empty_ring();
        ring_head  = 0;
        ring_tail  = 0;
        ring_count = 0;
        head_sent  = 0;
        for (int i = 0; i < NSLOTS; i++) begin
            slot_len[i]  = 0;
            slot_tele[i] = tcsq_pkg::CLASS_CTRL;
        end
    endfunction

    function automatic logic ctrl_queued();
        for (int k = 0; k < ring_count; k++) begin
            if (slot_tele[(ring_head + k) % NSLOTS] == tcsq_pkg::CLASS_CTRL)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Oldest telemetry slot that may be overwritten; a head already part
    // sent is skipped. Returns NSLOTS when there is none.
    function automatic int oldest_tele_slot();
        int idx;
        for (int k = 0; k < ring_count; k++) begin
            idx = (ring_head + k) % NSLOTS;
            if (slot_tele[idx] == tcsq_pkg::CLASS_TELE && !(k == 0 && head_sent != 0))
                return idx;
        end
        return NSLOTS;
    endfunction

    function automatic void pop_head();
        ring_head = (ring_head + 1) % NSLOTS;
        if (ring_count > 0)
            ring_count--;
        head_sent = 0;
    endfunction

    // Applies one command to the ring and returns the result it must give.
    function automatic t_queue_result apply_command(
        input logic [tcsq_pkg::CMD_W-1:0] cmd,
        input logic                       cls,
        input logic [tcsq_pkg::LEN_W-1:0] plen,
        input logic [tcsq_pkg::LEN_W-1:0] acc
    );
        t_queue_result r;
        int   idx;
        int   free_slots;
        int   remaining;
        int   take;
        logic room;
        r.ok         = 1'b0;
        r.slot_index = '0;
        r.coalesced  = 1'b0;
        r.frame_done = 1'b0;
        case (cmd)
            tcsq_pkg::CMD_ENQUEUE: begin
                if (plen != 0 && plen <= MAX_BYTES) begin
                    idx        = NSLOTS;
                    free_slots = NSLOTS - ring_count;
                    if (cls == tcsq_pkg::CLASS_TELE)
                        idx = oldest_tele_slot();
                    if (idx < NSLOTS) begin
                        // Coalesce into the queued telemetry packet.
                        slot_len[idx]  = int'(plen);
                        slot_tele[idx] = tcsq_pkg::CLASS_TELE;
                        r.ok           = 1'b1;
                        r.coalesced    = 1'b1;
                        r.slot_index   = tcsq_pkg::IDX_W'(idx);
                    end else begin
                        room = (cls == tcsq_pkg::CLASS_TELE)
                               ? (!ctrl_queued() && free_slots >= 2)
                               : (free_slots >= 1);
                        if (room) begin
                            idx            = ring_tail;
                            slot_len[idx]  = int'(plen);
                            slot_tele[idx] = cls;
                            ring_tail      = (ring_tail + 1) % NSLOTS;
                            ring_count++;
                            r.ok           = 1'b1;
                            r.slot_index   = tcsq_pkg::IDX_W'(idx);
                        end
                    end
                end
            end
            tcsq_pkg::CMD_TRANSPORT: begin
                if (ring_count != 0) begin
                    r.ok = 1'b1;
                    if (slot_len[ring_head] == 0) begin
                        // A head with no bytes leaves at once.
                        pop_head();
                        r.frame_done = 1'b1;
                    end else begin
                        remaining = slot_len[ring_head] - head_sent;
                        if (remaining < 0)
                            remaining = 0;
                        take = (int'(acc) < remaining) ? int'(acc) : remaining;
                        if (take != 0 || remaining == 0) begin
                            head_sent += take;
                            if (head_sent >= slot_len[ring_head]) begin
                                pop_head();
                                r.frame_done = 1'b1;
                            end
                        end
                    end
                end
            end
            tcsq_pkg::CMD_CLEAR: begin
                empty_ring();
                r.ok = 1'b1;
            end
            default: begin
            end
        endcase
        r.head_slot    = tcsq_pkg::IDX_W'(ring_head);
        r.head_offset  = tcsq_pkg::LEN_W'(head_sent);
        r.queue_count  = tcsq_pkg::COUNT_W'(ring_count);
        r.ctrl_pending = ctrl_queued();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender, receiver and result check
    // ------------------------------------------------------------------

    // Offers one item after a random gap and records its expected result
    // once the block has taken it.
    task automatic send_item(
        input logic [tcsq_pkg::CMD_W-1:0] cmd,
        input logic                       cls,
        input logic [tcsq_pkg::LEN_W-1:0] plen,
        input logic [tcsq_pkg::LEN_W-1:0] acc
    );
        int gap;
        t_queue_result r;
        gap = tx_idle_on ? $urandom_range(0, 12) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(tcsq_pkg::IN_TDATA_W - 2 * tcsq_pkg::LEN_W){1'b0}}, acc, plen};
        s_axis_tuser  <= {cls, cmd};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        r = apply_command(cmd, cls, plen, acc);
        expected_results.push_back(r);
    endtask

    // Receiver: random stalls per result, plus one long hold when asked.
    initial begin
        int stall;
        int holds_done;
        holds_done = 0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_holds_asked > holds_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
            end
            stall = rx_idle_on ? $urandom_range(0, 12) : 0;
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
        end
    end

    task automatic compare_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: mismatch in %s, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Every result item taken from the block is checked against the oldest
    // expectation.
    always @(posedge i_clk) begin
        t_queue_result exp_r;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result item with none expected, actual tdata 0x%06h",
                         $time, m_axis_tdata);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                compare_field("ok", int'(exp_r.ok), int'(m_axis_tdata[0]));
                compare_field("slot_index", int'(exp_r.slot_index),
                              int'(m_axis_tdata[2:1]));
                compare_field("coalesced", int'(exp_r.coalesced), int'(m_axis_tdata[3]));
                compare_field("frame_done", int'(exp_r.frame_done), int'(m_axis_tdata[4]));
                compare_field("head_slot", int'(exp_r.head_slot),
                              int'(m_axis_tdata[6:5]));
                compare_field("head_offset", int'(exp_r.head_offset),
                              int'(m_axis_tdata[16:7]));
                compare_field("queue_count", int'(exp_r.queue_count),
                              int'(m_axis_tdata[19:17]));
                compare_field("ctrl_pending", int'(exp_r.ctrl_pending),
                              int'(m_axis_tdata[20]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked sequence through the refusal rules, coalescing and
    // clamping of the transport count.
    task automatic test_directed();
        // Transport on an empty ring and an unknown command are refused.
        send_item(tcsq_pkg::CMD_TRANSPORT, tcsq_pkg::CLASS_CTRL, 10'd0, 10'd5);
        send_item(CMD_UNKNOWN, tcsq_pkg::CLASS_TELE, 10'd1023, 10'd1023);
        // Lengths of zero or beyond a slot are refused.
        send_item(tcsq_pkg::CMD_ENQUEUE, tcsq_pkg::CLASS_CTRL, 10'd0,    10'd0);
        send_item(tcsq_pkg::CMD_ENQUEUE, tcsq_pkg::CLASS_CTRL, 10'd257,  10'd0);
        send_item(tcsq_pkg::CMD_ENQUEUE, tcsq_pkg::CLASS_TELE, 10'd1023, 10'd0);
        // Telemetry is refused while control waits and nothing can coalesce.
        send_item(tcsq_pkg::CMD_ENQUEUE, tcsq_pkg::CLASS_CTRL, 10'd1,  10'd0);
        send_item(tcsq_pkg::CMD_ENQUEUE, tcsq_pkg::CLASS_TELE, 10'd50, 10'd0);
        // Zero bytes taken leave the head alone; a large count is clamped.
        send_item(tcsq_pkg::CMD_TRANSPORT, tcsq_pkg::CLASS_CTRL, 10'd0, 10'd0);
        send_item(tcsq_pkg::CMD_TRANSPORT, tcsq_pkg::CLASS_CTRL, 10'd0, 10'd1023);
        // Fill the ring with full-size control packets, then overflow it.
        repeat (NSLOTS)
            send_item(tcsq_pkg::CMD_ENQUEUE, tcsq_pkg::CLASS_CTRL, 10'(MAX_BYTES), 10'd0);
        send_item(tcsq_pkg::CMD_ENQUEUE, tcsq_pkg::CLASS_CTRL, 10'd10, 10'd0);
        send_item(tcsq_pkg::CMD_CLEAR,   tcsq_pkg::CLASS_TELE, 10'd1023, 10'd1023);
        // Coalescing, skipping a head that is part sent.
        send_item(tcsq_pkg::CMD_ENQUEUE,   tcsq_pkg::CLASS_TELE, 10'd100, 10'd0);
        send_item(tcsq_pkg::CMD_ENQUEUE,   tcsq_pkg::CLASS_TELE, 10'd200, 10'd0);
        send_item(tcsq_pkg::CMD_TRANSPORT, tcsq_pkg::CLASS_CTRL, 10'd0,   10'd10);
        send_item(tcsq_pkg::CMD_ENQUEUE,   tcsq_pkg::CLASS_TELE, 10'd30,  10'd0);
        send_item(tcsq_pkg::CMD_ENQUEUE,   tcsq_pkg::CLASS_TELE, 10'd40,  10'd0);
        send_item(tcsq_pkg::CMD_ENQUEUE,   tcsq_pkg::CLASS_CTRL, 10'd20,  10'd0);
        send_item(tcsq_pkg::CMD_ENQUEUE,   tcsq_pkg::CLASS_TELE, 10'd60,  10'd0);
        send_item(tcsq_pkg::CMD_TRANSPORT, tcsq_pkg::CLASS_CTRL, 10'd0,   10'd1023);
        send_item(tcsq_pkg::CMD_TRANSPORT, tcsq_pkg::CLASS_CTRL, 10'd0,   10'd1023);
        send_item(tcsq_pkg::CMD_CLEAR,     tcsq_pkg::CLASS_CTRL, 10'd0,   10'd0);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering items back to back, so the block must stall its input.
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_holds_asked++;
        repeat (3) send_item(tcsq_pkg::CMD_ENQUEUE, tcsq_pkg::CLASS_CTRL, 10'd40, 10'd0);
        repeat (3) send_item(tcsq_pkg::CMD_ENQUEUE, tcsq_pkg::CLASS_TELE, 10'd80, 10'd0);
        repeat (4) send_item(tcsq_pkg::CMD_TRANSPORT, tcsq_pkg::CLASS_CTRL, 10'd0, 10'd25);
        send_item(tcsq_pkg::CMD_CLEAR, tcsq_pkg::CLASS_CTRL, 10'd0, 10'd0);
        tx_idle_on = 1'b1;
    endtask

    // Random traffic, mostly well-formed enqueues and partial transports
    // so that the ring fills, coalesces and drains; the rest is noise.
    task automatic test_random();
        int pick;
        int sent;
        logic [tcsq_pkg::CMD_W-1:0] cmd;
        logic                       cls;
        logic [tcsq_pkg::LEN_W-1:0] plen;
        logic [tcsq_pkg::LEN_W-1:0] acc;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            // Change the idling pattern now and then, with spells of none.
            if (sent % 64 == 0) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            cls  = 1'($urandom_range(0, 1));
            plen = ($urandom_range(0, 9) != 0) ? 10'($urandom_range(1, MAX_BYTES))
                                               : 10'($urandom_range(0, 1023));
            case ($urandom_range(0, 9))
                0:       acc = 10'($urandom_range(0, 1023));
                1, 2:    acc = 10'($urandom_range(0, 300));
                default: acc = 10'($urandom_range(0, 100));
            endcase
            if (pick < 48)
                cmd = tcsq_pkg::CMD_ENQUEUE;
            else if (pick < 92)
                cmd = tcsq_pkg::CMD_TRANSPORT;
            else if (pick < 97)
                cmd = tcsq_pkg::CMD_CLEAR;
            else
                cmd = CMD_UNKNOWN;
            send_item(cmd, cls, plen, acc);
            sent++;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------

    initial begin
        empty_ring();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random();
        s_axis_tvalid <= 1'b0;

        // Let the last results drain, then allow for the block's latency.
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
